/* rtl/core/u8wd_pkg.sv */
// u8wd_pkg: shared types, constants and helper functions of the UTF-8 decoder.
// Used by every module under rtl/core; depends on nothing else.
`timescale 1ns / 1ps

package u8wd_pkg;

    // Field widths
    localparam int CODE_W  = 21;
    localparam int COUNT_W = 16;
    localparam int BYTE_W  = 8;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // Default depth of the queue between front and back
    localparam int QUEUE_DEPTH_DEF = 4;

    // Register reset values
    localparam logic               UTF16_OUT_RST = 1'b1;
    localparam logic [COUNT_W-1:0] MAX_UNITS_RST = 16'd512;

    // Register index, taken from paddr[2]
    typedef enum logic [0:0] {
        REG_UTF16_OUT = 1'b0,
        REG_MAX_UNITS = 1'b1
    } reg_idx_t;

    // Byte classification masks and tags
    localparam logic [BYTE_W-1:0] CONT_MASK  = 8'hc0;
    localparam logic [BYTE_W-1:0] CONT_TAG   = 8'h80;
    localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'he0;
    localparam logic [BYTE_W-1:0] LEAD2_TAG  = 8'hc0;
    localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'hf0;
    localparam logic [BYTE_W-1:0] LEAD3_TAG  = 8'he0;
    localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'hf8;
    localparam logic [BYTE_W-1:0] LEAD4_TAG  = 8'hf0;
    localparam logic [BYTE_W-1:0] END_BYTE   = 8'h00;

    // Code point constants
    localparam logic [CODE_W-1:0] REPLACEMENT = 21'h00fffd;
    localparam logic [CODE_W-1:0] CODE_MAX    = 21'h10ffff;
    localparam logic [CODE_W-1:0] SURR_LO     = 21'h00d800;
    localparam logic [CODE_W-1:0] SURR_HI     = 21'h00dfff;
    localparam logic [CODE_W-1:0] BMP_MAX     = 21'h00ffff;
    localparam logic [CODE_W-1:0] SUPP_BASE   = 21'h010000;
    localparam logic [CODE_W-1:0] HI_BASE     = 21'h00d800;
    localparam logic [CODE_W-1:0] LO_BASE     = 21'h00dc00;
    localparam logic [CODE_W-1:0] TEN_MASK    = 21'h0003ff;

    // One result item
    typedef struct packed {
        logic [CODE_W-1:0]  code_unit;
        logic               end_of_string;
        logic [COUNT_W-1:0] units_written;
    } result_t;

    // One queue entry: the results of one byte, slot 0 first
    typedef struct packed {
        logic               two;
        result_t [1:0]      res;
    } entry_t;

    // Configuration seen by the front
    typedef struct packed {
        logic               utf16_out;
        logic [COUNT_W-1:0] max_units;
    } cfg_t;

    // Build an ordinary result
    function automatic result_t make_unit(input logic [CODE_W-1:0] code);
        result_t r;
        r.code_unit     = code;
        r.end_of_string = 1'b0;
        r.units_written = '0;
        return r;
    endfunction

    // Replace out-of-range and surrogate values
    function automatic logic [CODE_W-1:0] sanitize(input logic [CODE_W-1:0] cp);
        logic bad;
        bad = (cp > CODE_MAX) || ((cp >= SURR_LO) && (cp <= SURR_HI));
        return bad ? REPLACEMENT : cp;
    endfunction

    // High surrogate of a supplementary code point
    function automatic logic [CODE_W-1:0] surr_high(input logic [CODE_W-1:0] cp);
        logic [CODE_W-1:0] v;
        v = cp - SUPP_BASE;
        return HI_BASE + (v >> 10);
    endfunction

    // Low surrogate of a supplementary code point
    function automatic logic [CODE_W-1:0] surr_low(input logic [CODE_W-1:0] cp);
        logic [CODE_W-1:0] v;
        v = cp - SUPP_BASE;
        return LO_BASE + (v & TEN_MASK);
    endfunction

endpackage

/* rtl/core/u8wd_regs.sv */
// u8wd_regs: APB configuration registers (utf16_out, max_units).
// Depends on u8wd_pkg.
`timescale 1ns / 1ps

module u8wd_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [u8wd_pkg::PADDR_W-1:0] paddr,
    input  logic [u8wd_pkg::PDATA_W-1:0] pwdata,
    output logic [u8wd_pkg::PDATA_W-1:0] prdata,
    output logic                         pready,
    output u8wd_pkg::cfg_t               cfg
);

    logic                          utf16_out_reg;
    logic                          utf16_out_next;
    logic [u8wd_pkg::COUNT_W-1:0]  max_units_reg;
    logic [u8wd_pkg::COUNT_W-1:0]  max_units_next;
    logic                          wr_en;
    u8wd_pkg::reg_idx_t            idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = u8wd_pkg::reg_idx_t'(paddr[2]);

    // Decode the write transfer
    always_comb
    begin
        utf16_out_next = utf16_out_reg;
        max_units_next = max_units_reg;
        if (wr_en)
        begin
            case (idx)
                u8wd_pkg::REG_UTF16_OUT: utf16_out_next = pwdata[0];
                u8wd_pkg::REG_MAX_UNITS: max_units_next = pwdata[u8wd_pkg::COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            utf16_out_reg <= u8wd_pkg::UTF16_OUT_RST;
            max_units_reg <= u8wd_pkg::MAX_UNITS_RST;
        end
        else
        begin
            utf16_out_reg <= utf16_out_next;
            max_units_reg <= max_units_next;
        end
    end

    // Return the addressed register
    always_comb
    begin
        case (idx)
            u8wd_pkg::REG_UTF16_OUT:
                prdata = {{(u8wd_pkg::PDATA_W-1){1'b0}}, utf16_out_reg};
            u8wd_pkg::REG_MAX_UNITS:
                prdata = {{(u8wd_pkg::PDATA_W-u8wd_pkg::COUNT_W){1'b0}}, max_units_reg};
            default:
                prdata = '0;
        endcase
    end

    assign cfg.utf16_out = utf16_out_reg;
    assign cfg.max_units = max_units_reg;

endmodule

/* rtl/core/u8wd_front.sv */
// u8wd_front: accepts bytes, tracks the decode state and builds queue entries
// holding the one or two results of each byte that has any. Depends on u8wd_pkg.
`timescale 1ns / 1ps

module u8wd_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [u8wd_pkg::BYTE_W-1:0] in_byte,
    input  u8wd_pkg::cfg_t              cfg,
    input  logic                        q_full,
    output logic                        push,
    output u8wd_pkg::entry_t            push_entry
);

    logic [u8wd_pkg::CODE_W-1:0]  part_reg;
    logic [u8wd_pkg::CODE_W-1:0]  part_next;
    logic [1:0]                   pend_reg;
    logic [1:0]                   pend_next;
    logic [u8wd_pkg::COUNT_W-1:0] cnt_reg;
    logic [u8wd_pkg::COUNT_W-1:0] cnt_next;
    logic                         stopped_reg;
    logic                         stopped_next;

    logic                         accept;
    logic [u8wd_pkg::CODE_W-1:0]  part_v;
    logic [1:0]                   pend_v;
    logic [u8wd_pkg::COUNT_W-1:0] cnt_v;
    logic                         stop_v;
    logic [1:0]                   n_v;
    u8wd_pkg::result_t [1:0]      res_v;
    logic                         done_v;
    logic [u8wd_pkg::CODE_W-1:0]  word_v;
    logic [u8wd_pkg::CODE_W-1:0]  cp_v;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    // Decode one byte against the running state
    always_comb
    begin
        part_v = part_reg;
        pend_v = pend_reg;
        cnt_v  = cnt_reg;
        stop_v = stopped_reg;
        n_v    = 2'd0;
        res_v  = '0;
        done_v = 1'b0;
        word_v = '0;
        cp_v   = '0;

        // Continuation or broken sequence
        if (pend_reg != 2'd0 && !stopped_reg)
        begin
            if ((in_byte & u8wd_pkg::CONT_MASK) == u8wd_pkg::CONT_TAG)
            begin
                word_v = {part_reg[14:0], in_byte[5:0]};
                pend_v = pend_reg - 2'd1;
                part_v = word_v;
                done_v = 1'b1;
                if (pend_v == 2'd0)
                begin
                    part_v = '0;
                    cp_v   = u8wd_pkg::sanitize(word_v);
                    if (cfg.utf16_out && (cp_v > u8wd_pkg::BMP_MAX))
                    begin
                        if (({1'b0, cnt_v} + 17'd2) >= {1'b0, cfg.max_units})
                        begin
                            stop_v = 1'b1;
                        end
                        else
                        begin
                            res_v[0] = u8wd_pkg::make_unit(u8wd_pkg::surr_high(cp_v));
                            res_v[1] = u8wd_pkg::make_unit(u8wd_pkg::surr_low(cp_v));
                            n_v      = 2'd2;
                            cnt_v    = cnt_v + 16'd2;
                        end
                    end
                    else
                    begin
                        res_v[0] = u8wd_pkg::make_unit(cp_v);
                        n_v      = 2'd1;
                        cnt_v    = cnt_v + 16'd1;
                    end
                end
            end
            else
            begin
                pend_v   = 2'd0;
                part_v   = '0;
                res_v[0] = u8wd_pkg::make_unit(u8wd_pkg::REPLACEMENT);
                n_v      = 2'd1;
                cnt_v    = cnt_v + 16'd1;
            end
        end

        // Lead byte, end of string or dropped byte
        if (!done_v)
        begin
            if (in_byte == u8wd_pkg::END_BYTE)
            begin
                res_v[n_v[0]].code_unit     = '0;
                res_v[n_v[0]].end_of_string = 1'b1;
                res_v[n_v[0]].units_written = cnt_v;
                n_v    = n_v + 2'd1;
                cnt_v  = '0;
                stop_v = 1'b0;
                pend_v = 2'd0;
                part_v = '0;
            end
            else if (!stop_v)
            begin
                if (({1'b0, cnt_v} + 17'd1) >= {1'b0, cfg.max_units})
                begin
                    stop_v = 1'b1;
                    pend_v = 2'd0;
                    part_v = '0;
                end
                else if (!in_byte[7])
                begin
                    res_v[n_v[0]] = u8wd_pkg::make_unit(
                        {{(u8wd_pkg::CODE_W-u8wd_pkg::BYTE_W){1'b0}}, in_byte});
                    n_v   = n_v + 2'd1;
                    cnt_v = cnt_v + 16'd1;
                end
                else if ((in_byte & u8wd_pkg::LEAD2_MASK) == u8wd_pkg::LEAD2_TAG)
                begin
                    part_v = {16'd0, in_byte[4:0]};
                    pend_v = 2'd1;
                end
                else if ((in_byte & u8wd_pkg::LEAD3_MASK) == u8wd_pkg::LEAD3_TAG)
                begin
                    part_v = {17'd0, in_byte[3:0]};
                    pend_v = 2'd2;
                end
                else if ((in_byte & u8wd_pkg::LEAD4_MASK) == u8wd_pkg::LEAD4_TAG)
                begin
                    part_v = {18'd0, in_byte[2:0]};
                    pend_v = 2'd3;
                end
                else
                begin
                    res_v[n_v[0]] = u8wd_pkg::make_unit(u8wd_pkg::REPLACEMENT);
                    n_v   = n_v + 2'd1;
                    cnt_v = cnt_v + 16'd1;
                end
            end
        end
    end

    // Advance the state only on an input transfer
    assign part_next    = accept ? part_v : part_reg;
    assign pend_next    = accept ? pend_v : pend_reg;
    assign cnt_next     = accept ? cnt_v  : cnt_reg;
    assign stopped_next = accept ? stop_v : stopped_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            part_reg    <= '0;
            pend_reg    <= 2'd0;
            cnt_reg     <= '0;
            stopped_reg <= 1'b0;
        end
        else
        begin
            part_reg    <= part_next;
            pend_reg    <= pend_next;
            cnt_reg     <= cnt_next;
            stopped_reg <= stopped_next;
        end
    end

    // Queue the results of this byte
    assign push           = accept && (n_v != 2'd0);
    assign push_entry.two = n_v[1];
    assign push_entry.res = res_v;

    // A stopped string never waits on continuation bytes
    a_stop_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
        stopped_reg |-> (pend_reg == 2'd0))
        else $error("continuation pending while output stopped");

    // Partial bits are cleared whenever no sequence is open
    a_idle_no_part: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_reg == 2'd0) |-> (part_reg == '0))
        else $error("stale partial code with no sequence open");

endmodule

/* rtl/core/u8wd_queue.sv */
// u8wd_queue: small register FIFO of decoded entries between front and back.
// Depends on u8wd_pkg.
`timescale 1ns / 1ps

module u8wd_queue #(
    parameter int QUEUE_DEPTH = u8wd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  u8wd_pkg::entry_t push_entry,
    output logic             full,
    input  logic             pop,
    output logic             q_valid,
    output u8wd_pkg::entry_t q_entry
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    u8wd_pkg::entry_t  mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              do_pop;

    assign full    = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_entry = mem_reg[rd_ptr_reg];
    assign do_pop  = pop && q_valid;

    // Advance pointers with wrap at the depth
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        count_next = count_reg + CNT_W'(push) - CNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed entry
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("push into a full queue");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

endmodule

/* rtl/core/u8wd_back.sv */
// u8wd_back: drains queue entries, one result per cycle unless out_ready stalls,
// into the output register. Depends on u8wd_pkg.
`timescale 1ns / 1ps

module u8wd_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_valid,
    input  u8wd_pkg::entry_t              q_entry,
    output logic                          pop,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [u8wd_pkg::CODE_W-1:0]   code_unit,
    output logic                          end_of_string,
    output logic [u8wd_pkg::COUNT_W-1:0]  units_written
);

    logic              out_valid_reg;
    logic              out_valid_next;
    u8wd_pkg::result_t out_data_reg;
    u8wd_pkg::result_t out_data_next;
    logic              idx_reg;
    logic              idx_next;
    logic              load;

    assign load = q_valid && (!out_valid_reg || out_ready);

    // Load the next result; pop once the last slot of the entry leaves
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        idx_next       = idx_reg;
        pop            = 1'b0;
        if (load)
        begin
            out_valid_next = 1'b1;
            out_data_next  = q_entry.res[idx_reg];
            if (idx_reg || !q_entry.two)
            begin
                pop      = 1'b1;
                idx_next = 1'b0;
            end
            else
            begin
                idx_next = 1'b1;
            end
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid     = out_valid_reg;
    assign code_unit     = out_data_reg.code_unit;
    assign end_of_string = out_data_reg.end_of_string;
    assign units_written = out_data_reg.units_written;

    // A half-drained pair keeps its entry at the queue head
    a_pair_held: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg |-> (q_valid && q_entry.two))
        else $error("second slot pending without its entry");

endmodule

/* rtl/core/utf8_to_wide_char_decoder_core.sv */
// Top level of the UTF-8 to wide-character decoder: APB registers, front decoder,
// entry queue and output back end. Depends on u8wd_pkg and the u8wd_* modules.
// Path: a byte's results enter the queue at its input transfer; the back end then
// loads them from the queue head into the output register, from which they transfer.
// Throughput: one byte per cycle while the queue is not full; the results of a byte
// leave in turn, paced by the single output register draining the queue.
`timescale 1ns / 1ps

module utf8_to_wide_char_decoder_core #(
    parameter int QUEUE_DEPTH = u8wd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [u8wd_pkg::PADDR_W-1:0]  paddr,
    input  logic [u8wd_pkg::PDATA_W-1:0]  pwdata,
    output logic [u8wd_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [u8wd_pkg::BYTE_W-1:0]   in_byte,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [u8wd_pkg::CODE_W-1:0]   code_unit,
    output logic                          end_of_string,
    output logic [u8wd_pkg::COUNT_W-1:0]  units_written
);

    // Reset: rst_n clears decode state, queue and output; utf16_out=1, max_units=512.

    u8wd_pkg::cfg_t   cfg;
    logic             q_full;
    logic             push;
    u8wd_pkg::entry_t push_entry;
    logic             pop;
    logic             q_valid;
    u8wd_pkg::entry_t q_entry;

    u8wd_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    u8wd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_byte    (in_byte),
        .cfg        (cfg),
        .q_full     (q_full),
        .push       (push),
        .push_entry (push_entry)
    );

    u8wd_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .q_valid    (q_valid),
        .q_entry    (q_entry)
    );

    u8wd_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_entry       (q_entry),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .code_unit     (code_unit),
        .end_of_string (end_of_string),
        .units_written (units_written)
    );

endmodule

/* tb/utf8_decode_check.sv */
// utf8_decode_check: watches the byte, result and register channels of the decoder core,
// predicts each result and compares it. Depends on u8wd_pkg only.
`timescale 1ns / 1ps

module utf8_decode_check (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic                          pready,
    input  logic [u8wd_pkg::PADDR_W-1:0]  paddr,
    input  logic [u8wd_pkg::PDATA_W-1:0]  pwdata,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic [u8wd_pkg::BYTE_W-1:0]   in_byte,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic [u8wd_pkg::CODE_W-1:0]   code_unit,
    input  logic                          end_of_string,
    input  logic [u8wd_pkg::COUNT_W-1:0]  units_written,
    output logic [31:0]                   fail_count,
    output logic [31:0]                   results_pending
);

    // Register copies
    logic                         mode_utf16;
    logic [u8wd_pkg::COUNT_W-1:0] capacity;

    // Decode state of the current string
    logic [u8wd_pkg::CODE_W-1:0]  acc_code;
    logic [1:0]                   cont_left;
    logic [u8wd_pkg::COUNT_W-1:0] units_so_far;
    logic                         capacity_hit;

    u8wd_pkg::result_t            expected_units[$];
    int                           errors;

    // Queue one ordinary unit and count it
    task automatic push_unit(input logic [u8wd_pkg::CODE_W-1:0] unit);
        u8wd_pkg::result_t r;
        r.code_unit     = unit;
        r.end_of_string = 1'b0;
        r.units_written = '0;
        expected_units.push_back(r);
        units_so_far = units_so_far + 16'd1;
    endtask

    // Turn a finished code point into one unit or a surrogate pair
    task automatic emit_point(input logic [u8wd_pkg::CODE_W-1:0] cp);
        logic [u8wd_pkg::CODE_W-1:0] v;
        v = cp;
        if (v > u8wd_pkg::CODE_MAX || (v >= u8wd_pkg::SURR_LO && v <= u8wd_pkg::SURR_HI))
            v = u8wd_pkg::REPLACEMENT;
        if (mode_utf16 && v > u8wd_pkg::BMP_MAX)
        begin
            // a pair that would not fit stops the string
            if ({1'b0, units_so_far} + 17'd2 >= {1'b0, capacity})
                capacity_hit = 1'b1;
            else
            begin
                v = v - u8wd_pkg::SUPP_BASE;
                push_unit(u8wd_pkg::HI_BASE + (v >> 10));
                push_unit(u8wd_pkg::LO_BASE + (v & u8wd_pkg::TEN_MASK));
            end
        end
        else
            push_unit(v);
    endtask

    // Advance the prediction by one accepted byte
    task automatic decode_byte(input logic [u8wd_pkg::BYTE_W-1:0] b);
        u8wd_pkg::result_t r;
        if (cont_left != 2'd0 && !capacity_hit)
        begin
            if ((b & u8wd_pkg::CONT_MASK) == u8wd_pkg::CONT_TAG)
            begin
                acc_code  = {acc_code[u8wd_pkg::CODE_W-7:0], b[5:0]};
                cont_left = cont_left - 2'd1;
                if (cont_left == 2'd0)
                begin
                    emit_point(acc_code);
                    acc_code = '0;
                end
                return;
            end
            // broken sequence: replace, then treat the byte as a new lead
            cont_left = 2'd0;
            acc_code  = '0;
            push_unit(u8wd_pkg::REPLACEMENT);
        end

        if (b == u8wd_pkg::END_BYTE)
        begin
            r.code_unit     = '0;
            r.end_of_string = 1'b1;
            r.units_written = units_so_far;
            expected_units.push_back(r);
            acc_code     = '0;
            cont_left    = 2'd0;
            units_so_far = '0;
            capacity_hit = 1'b0;
            return;
        end
        if (capacity_hit)
            return;
        if ({1'b0, units_so_far} + 17'd1 >= {1'b0, capacity})
        begin
            capacity_hit = 1'b1;
            cont_left    = 2'd0;
            acc_code     = '0;
            return;
        end

        if (b < u8wd_pkg::CONT_TAG)
            emit_point({{(u8wd_pkg::CODE_W-u8wd_pkg::BYTE_W){1'b0}}, b});
        else if ((b & u8wd_pkg::LEAD2_MASK) == u8wd_pkg::LEAD2_TAG)
        begin
            acc_code  = {{(u8wd_pkg::CODE_W-5){1'b0}}, b[4:0]};
            cont_left = 2'd1;
        end
        else if ((b & u8wd_pkg::LEAD3_MASK) == u8wd_pkg::LEAD3_TAG)
        begin
            acc_code  = {{(u8wd_pkg::CODE_W-4){1'b0}}, b[3:0]};
            cont_left = 2'd2;
        end
        else if ((b & u8wd_pkg::LEAD4_MASK) == u8wd_pkg::LEAD4_TAG)
        begin
            acc_code  = {{(u8wd_pkg::CODE_W-3){1'b0}}, b[2:0]};
            cont_left = 2'd3;
        end
        else
            push_unit(u8wd_pkg::REPLACEMENT);
    endtask

    // Compare results, follow register writes, then predict the new byte
    always @(posedge clk or negedge rst_n)
    begin
        u8wd_pkg::result_t want;
        if (!rst_n)
        begin
            mode_utf16   = u8wd_pkg::UTF16_OUT_RST;
            capacity     = u8wd_pkg::MAX_UNITS_RST;
            acc_code     = '0;
            cont_left    = 2'd0;
            units_so_far = '0;
            capacity_hit = 1'b0;
            expected_units.delete();
            errors = 0;
            fail_count      <= '0;
            results_pending <= '0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_units.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result: expected none, got unit %h end %b count %0d",
                             $time, code_unit, end_of_string, units_written);
                end
                else
                begin
                    want = expected_units.pop_front();
                    if (code_unit !== want.code_unit)
                    begin
                        errors++;
                        $display("%0t: code_unit mismatch: expected %h, got %h",
                                 $time, want.code_unit, code_unit);
                    end
                    if (end_of_string !== want.end_of_string)
                    begin
                        errors++;
                        $display("%0t: end_of_string mismatch: expected %b, got %b",
                                 $time, want.end_of_string, end_of_string);
                    end
                    if (units_written !== want.units_written)
                    begin
                        errors++;
                        $display("%0t: units_written mismatch: expected %0d, got %0d",
                                 $time, want.units_written, units_written);
                    end
                end
            end

            if (psel && penable && pwrite && pready)
            begin
                case (u8wd_pkg::reg_idx_t'(paddr[2]))
                    u8wd_pkg::REG_UTF16_OUT: mode_utf16 = pwdata[0];
                    u8wd_pkg::REG_MAX_UNITS: capacity   = pwdata[u8wd_pkg::COUNT_W-1:0];
                    default: ;
                endcase
            end

            if (in_valid && in_ready)
                decode_byte(in_byte);

            fail_count      <= 32'(errors);
            results_pending <= 32'(expected_units.size());
        end
    end

endmodule

/* tb/tb_utf8_to_wide_char_decoder_core.sv */
// tb_utf8_to_wide_char_decoder_core: byte stimulus, register phases and verdict for the
// decoder core. Depends on u8wd_pkg, utf8_to_wide_char_decoder_core and utf8_decode_check.
`timescale 1ns / 1ps

module tb_utf8_to_wide_char_decoder_core;

    localparam int NUM_PHASES   = 10;
    localparam int PHASE_BYTES  = 200;
    localparam int DRAIN_CYCLES = 4;
    localparam int TAIL_CYCLES  = 10;
    localparam int STALL_LIMIT  = 2000;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [u8wd_pkg::PADDR_W-1:0]  paddr;
    logic [u8wd_pkg::PDATA_W-1:0]  pwdata;
    logic [u8wd_pkg::PDATA_W-1:0]  prdata;
    logic                          pready;
    logic                          in_valid;
    logic                          in_ready;
    logic [u8wd_pkg::BYTE_W-1:0]   in_byte;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    logic [u8wd_pkg::CODE_W-1:0]   code_unit;
    logic                          end_of_string;
    logic [u8wd_pkg::COUNT_W-1:0]  units_written;

    logic [31:0]                   fail_count;
    logic [31:0]                   results_pending;

    logic                          calm_phase = 1'b0;
    logic [u8wd_pkg::BYTE_W-1:0]   tx_bytes[$];
    int                            phase_count;
    int                            idle_cycles;
    bit                            drained_once;

    utf8_to_wide_char_decoder_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .in_byte       (in_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .code_unit     (code_unit),
        .end_of_string (end_of_string),
        .units_written (units_written)
    );

    utf8_decode_check u_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .pready          (pready),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .in_byte         (in_byte),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .code_unit       (code_unit),
        .end_of_string   (end_of_string),
        .units_written   (units_written),
        .fail_count      (fail_count),
        .results_pending (results_pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Stall the result side at random outside calm phases
    always @(posedge clk)
    begin
        if (calm_phase)
            out_ready <= 1'b1;
        else
            out_ready <= ($urandom_range(99, 0) >= 11);
    end

    // Drop the run if no transfer happens for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (psel && penable && pwrite && pready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("tb_utf8_to_wide_char_decoder_core failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Register write: setup cycle, then access cycle until pready
    task automatic reg_write(input u8wd_pkg::reg_idx_t idx,
                             input logic [u8wd_pkg::PDATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Hold the input until every expected result is out
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (results_pending != 0) @(posedge clk);
    endtask

    // Transfer every queued byte, idling now and then
    task automatic send_queued();
        logic [u8wd_pkg::BYTE_W-1:0] nb;
        while (tx_bytes.size() != 0)
        begin
            nb = tx_bytes.pop_front();
            if (!calm_phase && $urandom_range(99, 0) < 11)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
            in_valid <= 1'b1;
            in_byte  <= nb;
            @(posedge clk);
            while (!in_ready) @(posedge clk);
            phase_count++;
        end
    endtask

    function automatic logic [u8wd_pkg::BYTE_W-1:0] cont_byte();
        logic [5:0] payload;
        payload = 6'($urandom_range(63, 0));
        return u8wd_pkg::CONT_TAG | {2'b00, payload};
    endfunction

    // Build one zero-terminated string: mostly well-formed sequences, some noise
    // and some sequences cut short by a non-continuation byte
    task automatic build_string();
        int                          n;
        int                          pick;
        int                          need;
        int                          k;
        logic [u8wd_pkg::BYTE_W-1:0] r8;
        logic [u8wd_pkg::BYTE_W-1:0] lead;
        n = ($urandom_range(9, 0) == 0) ? $urandom_range(40, 20) : $urandom_range(10, 0);
        repeat (n)
        begin
            pick = $urandom_range(99, 0);
            r8   = 8'($urandom_range(255, 0));
            if (pick < 30)
            begin
                r8 = 8'($urandom_range(127, 1));
                tx_bytes.push_back(r8);
            end
            else if (pick >= 78 && pick < 86)
            begin
                if (pick < 82)
                    r8 = 8'($urandom_range(255, 248));
                tx_bytes.push_back(r8);
            end
            else
            begin
                if (pick < 45)
                    need = 1;
                else if (pick < 60)
                    need = 2;
                else if (pick < 78)
                    need = 3;
                else
                    need = $urandom_range(3, 1);
                case (need)
                    1:       lead = u8wd_pkg::LEAD2_TAG | (r8 & ~u8wd_pkg::LEAD2_MASK);
                    2:       lead = u8wd_pkg::LEAD3_TAG | (r8 & ~u8wd_pkg::LEAD3_MASK);
                    default: lead = u8wd_pkg::LEAD4_TAG | (r8 & ~u8wd_pkg::LEAD4_MASK);
                endcase
                tx_bytes.push_back(lead);
                k = (pick < 78) ? need : $urandom_range(need - 1, 0);
                repeat (k) tx_bytes.push_back(cont_byte());
                // break the sequence with plain text, another lead or the end byte
                if (pick >= 86)
                begin
                    case ($urandom_range(2, 0))
                        0:       r8 = 8'($urandom_range(127, 1));
                        1:       r8 = 8'($urandom_range(255, 192));
                        default: r8 = u8wd_pkg::END_BYTE;
                    endcase
                    tx_bytes.push_back(r8);
                end
            end
        end
        tx_bytes.push_back(u8wd_pkg::END_BYTE);
    endtask

    // Register setting of each random phase; the extremes come first
    task automatic pick_setting(input int ph, output logic u16,
                                output logic [u8wd_pkg::COUNT_W-1:0] cap);
        case (ph)
            0:       begin u16 = 1'b0; cap = 16'hffff; end
            1:       begin u16 = 1'b1; cap = 16'd1;    end
            2:       begin u16 = 1'b1; cap = 16'd0;    end
            3:       begin u16 = 1'b1; cap = 16'd3;    end
            4:       begin u16 = 1'b0; cap = 16'd2;    end
            5:       begin u16 = 1'b1; cap = 16'hffff; end
            default:
            begin
                u16 = 1'($urandom_range(1, 0));
                cap = 16'($urandom_range(24, 2));
            end
        endcase
    endtask

    initial
    begin
        int                           ph;
        logic                         u16;
        logic [u8wd_pkg::COUNT_W-1:0] cap;

        rst_n    <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        in_valid <= 1'b0;
        in_byte  <= '0;
        drained_once = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed bytes at reset settings: plain text, two/three/four-byte forms,
        // a surrogate, a value above the last code point, a bad lead, a stray
        // continuation, a sequence broken by text and one broken by the end byte
        tx_bytes = {8'h41, 8'h7f, 8'hc3, 8'ha9, 8'he2, 8'h82, 8'hac,
                    8'hf0, 8'h9f, 8'h98, 8'h80, 8'hed, 8'ha0, 8'h80,
                    8'hf4, 8'h90, 8'h80, 8'h80, 8'hff, 8'h80, 8'hc3, 8'h41,
                    u8wd_pkg::END_BYTE, 8'he2, u8wd_pkg::END_BYTE};
        send_queued();

        for (ph = 0; ph < NUM_PHASES; ph++)
        begin
            drain_results();
            repeat (DRAIN_CYCLES) @(posedge clk);
            pick_setting(ph, u16, cap);
            reg_write(u8wd_pkg::REG_UTF16_OUT, {{(u8wd_pkg::PDATA_W-1){1'b0}}, u16});
            reg_write(u8wd_pkg::REG_MAX_UNITS,
                      {{(u8wd_pkg::PDATA_W-u8wd_pkg::COUNT_W){1'b0}}, cap});
            calm_phase <= (ph == 0);
            phase_count = 0;
            while (phase_count < PHASE_BYTES)
            begin
                build_string();
                send_queued();
                // pause now and then until the block has caught up
                if (!drained_once || $urandom_range(24, 0) == 0)
                begin
                    drained_once = 1'b1;
                    drain_results();
                end
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("tb_utf8_to_wide_char_decoder_core passed");
        else
            $display("tb_utf8_to_wide_char_decoder_core failed");
        $finish;
    end

endmodule
